### sv/yjk_pkg.sv
package yjk_pkg;

  localparam int BYTE_W    = 8;
  localparam int LUMA_W    = 5;
  localparam int CHROMA_W  = 6;
  localparam int CHAN_W    = 8;
  localparam int ENTRY_W   = 9;
  localparam int ENTRIES   = 16;
  localparam int PALETTE_W = ENTRY_W * ENTRIES;
  localparam int DATA_W    = 54;
  localparam int INDEX_W   = 2;

  typedef enum logic [INDEX_W-1:0] {
    REG_ATTRIBUTE_MODE = 2'd0,
    REG_PALETTE_LOW    = 2'd1,
    REG_PALETTE_MID    = 2'd2,
    REG_PALETTE_HIGH   = 2'd3
  } yjk_reg_t;

  // One pixel on its way from the group register into the color pipeline.
  typedef struct packed {
    logic [LUMA_W-1:0]          y;
    logic signed [CHROMA_W-1:0] k;
    logic signed [CHROMA_W-1:0] j;
    logic                       last;
  } yjk_pixel_t;

endpackage

### sv/yjk_serializer.sv
module yjk_serializer import yjk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] pixel_byte_0,
  input  logic [BYTE_W-1:0] pixel_byte_1,
  input  logic [BYTE_W-1:0] pixel_byte_2,
  input  logic [BYTE_W-1:0] pixel_byte_3,
  output logic              pix_valid,
  input  logic              pix_ready,
  output yjk_pixel_t        pix
);

  logic [BYTE_W-1:0]          group_bytes [4];
  logic signed [CHROMA_W-1:0] k;
  logic signed [CHROMA_W-1:0] j;
  logic [1:0]                 count;
  logic                       group_valid;
  logic                       take;
  logic                       take_last;
  logic                       accept;

  assign take      = group_valid && pix_ready;
  assign take_last = take && (count == 2'd3);
  // Take a new group while the last pixel of the current one leaves.
  assign in_stall  = group_valid && !take_last;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_valid <= 1'b0;
      count       <= 2'd0;
    end else begin
      if (accept) begin
        group_valid <= 1'b1;
      end else if (take_last) begin
        group_valid <= 1'b0;
      end
      // Count wraps to zero on the last pixel, ready for the next group.
      if (take) begin
        count <= count + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      group_bytes[0] <= pixel_byte_0;
      group_bytes[1] <= pixel_byte_1;
      group_bytes[2] <= pixel_byte_2;
      group_bytes[3] <= pixel_byte_3;
      k <= {pixel_byte_1[2:0], pixel_byte_0[2:0]};
      j <= {pixel_byte_3[2:0], pixel_byte_2[2:0]};
    end
  end

  always_comb begin
    pix_valid = group_valid;
    pix.y     = group_bytes[count][BYTE_W-1:BYTE_W-LUMA_W];
    pix.k     = k;
    pix.j     = j;
    pix.last  = (count == 2'd3);
  end

endmodule

### sv/yjk_decode.sv
module yjk_decode import yjk_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 pix_valid,
  output logic                 pix_ready,
  input  yjk_pixel_t           pix,
  input  logic                 attribute_mode,
  input  logic [PALETTE_W-1:0] palette,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [CHAN_W-1:0]    red,
  output logic [CHAN_W-1:0]    green,
  output logic [CHAN_W-1:0]    blue,
  output logic                 last_of_group
);

  function automatic logic [LUMA_W-1:0] clamp7(input logic [6:0] v);
    logic [LUMA_W-1:0] r;
    if (v[6]) begin
      r = '0;
    end else if (v[5]) begin
      r = '1;
    end else begin
      r = v[LUMA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [CHAN_W-1:0] widen5(input logic [LUMA_W-1:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [CHAN_W-1:0] widen3(input logic [2:0] v);
    return {v, v, v[2:1]};
  endfunction

  // Stage 1: sums
  logic              v1;
  logic [6:0]        red_sum;
  logic [6:0]        green_sum;
  logic [8:0]        blue_sum;
  logic              pal1;
  logic [3:0]        idx1;
  logic              last1;
  // Stage 2: clamped channels and palette entry
  logic              v2;
  logic [LUMA_W-1:0] r5;
  logic [LUMA_W-1:0] g5;
  logic [LUMA_W-1:0] b5;
  logic [ENTRY_W-1:0] entry;
  logic              pal2;
  logic              last2;

  logic              ready1;
  logic              ready2;
  logic              ready3;

  logic [6:0]        red_sum_next;
  logic [6:0]        green_sum_next;
  logic [8:0]        blue_sum_next;
  logic [LUMA_W-1:0] b5_next;

  assign ready3    = !out_valid || !out_stall;
  assign ready2    = !v2 || ready3;
  assign ready1    = !v1 || ready2;
  assign pix_ready = ready1;

  always_comb begin
    red_sum_next   = {2'b00, pix.y} + {pix.j[5], pix.j};
    green_sum_next = {2'b00, pix.y} + {pix.k[5], pix.k};
    blue_sum_next  = {2'b00, pix.y, 2'b00} + {4'b0000, pix.y}
                   - {{2{pix.j[5]}}, pix.j, 1'b0}
                   - {{3{pix.k[5]}}, pix.k} + 9'd2;
    // Negative sum truncates toward zero and clamps to zero either way.
    if (blue_sum[8]) begin
      b5_next = '0;
    end else if (blue_sum[7]) begin
      b5_next = '1;
    end else begin
      b5_next = blue_sum[6:2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= pix_valid;
      if (ready2) v2 <= v1;
      if (ready3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      red_sum   <= red_sum_next;
      green_sum <= green_sum_next;
      blue_sum  <= blue_sum_next;
      pal1      <= attribute_mode && pix.y[0];
      idx1      <= pix.y[LUMA_W-1:1];
      last1     <= pix.last;
    end
    if (ready2) begin
      r5    <= clamp7(red_sum);
      g5    <= clamp7(green_sum);
      b5    <= b5_next;
      entry <= palette[ENTRY_W*idx1 +: ENTRY_W];
      pal2  <= pal1;
      last2 <= last1;
    end
    if (ready3) begin
      if (pal2) begin
        red   <= widen3(entry[8:6]);
        green <= widen3(entry[5:3]);
        blue  <= widen3(entry[2:0]);
      end else begin
        red   <= widen5(r5);
        green <= widen5(g5);
        blue  <= widen5(b5);
      end
      last_of_group <= last2;
    end
  end

endmodule

### sv/yjk_to_rgb_converter_top.sv
// Color decoder for groups of four luma/chroma pixel bytes.
//
// Input channel: in_valid / in_stall with pixel_byte_0..3, one group per beat.
// Output channel: out_valid / out_stall with red, green, blue and
// last_of_group, one RGB888 pixel per beat; last_of_group marks the fourth.
// Configuration: write_enable, register_index, write_data; a register is
// written at the clock edge with write_enable high. Index 0 is attribute
// mode, 1..3 hold the palette. Write only while the block is idle.
//
// The first pixel of an accepted group passes through the sum, clamp and
// output registers of the decoder. Throughput: one pixel per cycle while
// the receiver does not stall, fed from the four-pixel group register.
// A new group is taken in the cycle its predecessor's last pixel moves on.
//
// Reset clears all valid bits and the configuration registers.
// When the receiver stalls, each pipeline stage holds until the one after
// it frees up; no beat is lost or repeated, and in_stall rises once the
// group register is still busy.
module yjk_to_rgb_converter_top import yjk_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] pixel_byte_0,
  input  logic [BYTE_W-1:0] pixel_byte_1,
  input  logic [BYTE_W-1:0] pixel_byte_2,
  input  logic [BYTE_W-1:0] pixel_byte_3,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CHAN_W-1:0] red,
  output logic [CHAN_W-1:0] green,
  output logic [CHAN_W-1:0] blue,
  output logic              last_of_group,
  input  logic              write_enable,
  input  logic [INDEX_W-1:0] register_index,
  input  logic [DATA_W-1:0] write_data
);

  logic                 attribute_mode;
  logic [DATA_W-1:0]    palette_low;
  logic [DATA_W-1:0]    palette_mid;
  logic [35:0]          palette_high;
  logic                 pix_valid;
  logic                 pix_ready;
  yjk_pixel_t           pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      attribute_mode <= 1'b0;
      palette_low    <= '0;
      palette_mid    <= '0;
      palette_high   <= '0;
    end else if (write_enable) begin
      unique case (yjk_reg_t'(register_index))
        REG_ATTRIBUTE_MODE: attribute_mode <= write_data[0];
        REG_PALETTE_LOW:    palette_low    <= write_data;
        REG_PALETTE_MID:    palette_mid    <= write_data;
        REG_PALETTE_HIGH:   palette_high   <= write_data[35:0];
        default: ;
      endcase
    end
  end

  yjk_serializer u_serializer (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_byte_0 (pixel_byte_0),
    .pixel_byte_1 (pixel_byte_1),
    .pixel_byte_2 (pixel_byte_2),
    .pixel_byte_3 (pixel_byte_3),
    .pix_valid    (pix_valid),
    .pix_ready    (pix_ready),
    .pix          (pix)
  );

  yjk_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .pix_valid      (pix_valid),
    .pix_ready      (pix_ready),
    .pix            (pix),
    .attribute_mode (attribute_mode),
    .palette        ({palette_high, palette_mid, palette_low}),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .last_of_group  (last_of_group)
  );

endmodule

### sim/yjk_to_rgb_converter_top_test.sv
`timescale 1ns / 100ps

module yjk_to_rgb_converter_top_test;
  import yjk_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } rgb_pixel_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] pixel_byte_0;
  logic [BYTE_W-1:0] pixel_byte_1;
  logic [BYTE_W-1:0] pixel_byte_2;
  logic [BYTE_W-1:0] pixel_byte_3;
  logic              out_valid;
  logic              out_stall;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              last_of_group;
  logic              write_enable;
  yjk_reg_t          register_index;
  logic [DATA_W-1:0] write_data;

  // Local copy of the configuration, updated only while the block is idle
  logic                 attr_mode_cfg;
  logic [PALETTE_W-1:0] palette_cfg;

  rgb_pixel_t pixels_due[$];
  int         error_count;
  int         cycle_count;
  logic       no_gaps;

  yjk_to_rgb_converter_top uut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .pixel_byte_0   (pixel_byte_0),
    .pixel_byte_1   (pixel_byte_1),
    .pixel_byte_2   (pixel_byte_2),
    .pixel_byte_3   (pixel_byte_3),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .last_of_group  (last_of_group),
    .write_enable   (write_enable),
    .register_index (register_index),
    .write_data     (write_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** yjk_to_rgb_converter_top: FAILED **");
      $finish;
    end
  end

  function automatic int draw_wait();
    if (no_gaps) return 0;
    return $urandom_range(0, 12);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[DATA_W-1:0];
  endfunction

  function automatic logic [31:0] make_group(input logic [4:0] y0, y1, y2, y3,
                                             input logic signed [5:0] kc, jc);
    return {y3, jc[5:3], y2, jc[2:0], y1, kc[5:3], y0, kc[2:0]};
  endfunction

  function automatic logic [CHAN_W-1:0] widen3(input logic [2:0] level);
    return {level, level, level[2:1]};
  endfunction

  function automatic logic [CHAN_W-1:0] widen5(input int level);
    logic [4:0] lv;
    if (level < 0) level = 0;
    if (level > 31) level = 31;
    lv = level[4:0];
    return {lv, lv[4:2]};
  endfunction

  // Work out the four pixels of one group and queue them in order.
  function automatic void decode_group(input logic [31:0] grp);
    logic [BYTE_W-1:0]  b [4];
    logic signed [5:0]  kc;
    logic signed [5:0]  jc;
    logic [ENTRY_W-1:0] entry;
    int                 y;
    int                 bs;
    rgb_pixel_t         px;
    for (int i = 0; i < 4; i++) b[i] = grp[8*i +: 8];
    kc = {b[1][2:0], b[0][2:0]};
    jc = {b[3][2:0], b[2][2:0]};
    for (int i = 0; i < 4; i++) begin
      y = b[i][7:3];
      if (attr_mode_cfg && (y % 2 == 1)) begin
        entry = palette_cfg[ENTRY_W*(y/2) +: ENTRY_W];
        px.red   = widen3(entry[8:6]);
        px.green = widen3(entry[5:3]);
        px.blue  = widen3(entry[2:0]);
      end else begin
        // int division truncates toward zero before the clamp
        bs = 5 * y - 2 * jc - kc + 2;
        px.red   = widen5(y + jc);
        px.green = widen5(y + kc);
        px.blue  = widen5(bs / 4);
      end
      px.last = (i == 3);
      pixels_due.push_back(px);
    end
  endfunction

  // Leaves valid high on return; wait_idle or a gap in the next call drops it.
  task automatic send_group(input logic [31:0] grp);
    int   gap;
    logic taken;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    pixel_byte_0 <= grp[7:0];
    pixel_byte_1 <= grp[15:8];
    pixel_byte_2 <= grp[23:16];
    pixel_byte_3 <= grp[31:24];
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    decode_group(grp);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] mode_word, low_word, mid_word,
                            high_word);
    write_enable   <= 1'b1;
    register_index <= REG_ATTRIBUTE_MODE;
    write_data     <= mode_word;
    @(posedge clk);
    register_index <= REG_PALETTE_LOW;
    write_data     <= low_word;
    @(posedge clk);
    register_index <= REG_PALETTE_MID;
    write_data     <= mid_word;
    @(posedge clk);
    register_index <= REG_PALETTE_HIGH;
    write_data     <= high_word;
    @(posedge clk);
    write_enable   <= 1'b0;
    // bits beyond each register's width are dropped
    attr_mode_cfg = mode_word[0];
    palette_cfg   = {high_word[35:0], mid_word, low_word};
  endtask

  task automatic test_yjk_corners();
    wait_idle();
    set_config({{(DATA_W-1){1'b1}}, 1'b0}, '0, '0, '0);
    send_group(make_group(0, 0, 0, 0, 0, 0));
    send_group(32'hFFFF_FFFF);
    send_group(make_group(31, 31, 31, 31, 31, 31));
    send_group(make_group(0, 0, 0, 0, -32, -32));
    send_group(make_group(0, 1, 2, 3, 0, 1));
    // small negative blue sums truncate to zero
    send_group(make_group(0, 0, 0, 0, 1, 1));
    send_group(make_group(0, 0, 0, 0, 1, 2));
    send_group(make_group(31, 0, 16, 1, -32, 31));
    send_group(make_group(10, 20, 5, 25, -5, 7));
    send_group(32'h5A5A_A5A5);
  endtask

  task automatic test_palette_lookup();
    wait_idle();
    set_config(54'h2A_AAAA_AAAA_AAAB, 54'h15_5AA5_3C96_0F1E, 54'h2C_3B4A_5968_7786,
               {DATA_W{1'b1}});
    send_group(make_group(1, 3, 5, 7, 3, -4));
    send_group(make_group(9, 11, 13, 15, -1, 12));
    send_group(make_group(17, 19, 21, 23, 31, -32));
    send_group(make_group(25, 27, 29, 31, 0, 0));
    // even luma still decodes as color difference in attribute mode
    send_group(make_group(0, 1, 30, 31, -32, 31));
    send_group(make_group(2, 4, 6, 8, 5, -6));
    wait_idle();
    set_config(54'h1, '0, '0, '0);
    send_group(make_group(31, 1, 15, 17, 0, 0));
    wait_idle();
    set_config(54'h1, {DATA_W{1'b1}}, {DATA_W{1'b1}}, '0);
    send_group(make_group(3, 13, 23, 29, -7, 9));
  endtask

  task automatic test_random_yjk();
    wait_idle();
    set_config(rand_word() & ~DATA_W'(1), rand_word(), rand_word(), rand_word());
    for (int n = 0; n < 50; n++) begin
      if (n % 20 == 0) no_gaps = 1'($urandom_range(0, 1));
      send_group({rand_byte(), rand_byte(), rand_byte(), rand_byte()});
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_random_palette();
    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      set_config(rand_word() | DATA_W'(1), rand_word(), rand_word(), rand_word());
      for (int n = 0; n < 27; n++) begin
        if (n % 9 == 0) no_gaps = 1'($urandom_range(0, 1));
        send_group({rand_byte(), rand_byte(), rand_byte(), rand_byte()});
      end
    end
    no_gaps = 1'b0;
  endtask

  // Receiver: hold out_stall for a random wait from draw_wait, then take one beat and check it.
  initial begin : pixel_check
    rgb_pixel_t got;
    rgb_pixel_t want;
    int         hold;
    logic       seen;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do begin
        @(negedge clk);
        seen = (out_valid === 1'b1);
        got.red   = red;
        got.green = green;
        got.blue  = blue;
        got.last  = last_of_group;
        @(posedge clk);
      end while (!seen);
      if (pixels_due.size() == 0) begin
        $error("unexpected pixel beat: red %0d green %0d blue %0d last %0d",
               got.red, got.green, got.blue, got.last);
        error_count++;
      end else begin
        want = pixels_due.pop_front();
        if (got.red !== want.red) begin
          $error("red mismatch: expected %0d, got %0d", want.red, got.red);
          error_count++;
        end
        if (got.green !== want.green) begin
          $error("green mismatch: expected %0d, got %0d", want.green, got.green);
          error_count++;
        end
        if (got.blue !== want.blue) begin
          $error("blue mismatch: expected %0d, got %0d", want.blue, got.blue);
          error_count++;
        end
        if (got.last !== want.last) begin
          $error("last_of_group mismatch: expected %0d, got %0d", want.last, got.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count    = 0;
    no_gaps        = 1'b0;
    attr_mode_cfg  = 1'b0;
    palette_cfg    = '0;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    pixel_byte_0   <= '0;
    pixel_byte_1   <= '0;
    pixel_byte_2   <= '0;
    pixel_byte_3   <= '0;
    write_enable   <= 1'b0;
    register_index <= REG_ATTRIBUTE_MODE;
    write_data     <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // reset values first: plain decode with an empty palette
    send_group(make_group(31, 15, 7, 1, -3, 2));
    test_yjk_corners();
    test_palette_lookup();
    test_random_yjk();
    test_random_palette();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pixels_due.size() == 0) begin
      $display("** yjk_to_rgb_converter_top: PASSED **");
    end else begin
      $display("** yjk_to_rgb_converter_top: FAILED **");
    end
    $finish;
  end

endmodule
